// ===== sv/bma_pkg.sv =====
// Shared constants, types and index helpers for the buddy memory allocator.
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;

   localparam int MAX_ORDER  = 10;
   localparam int ADDR_W     = 10;
   localparam int ORD_W      = 4;
   localparam int SIZE_W     = 11;
   localparam int MASK_W     = MAX_ORDER + 1;
   localparam int NODE_W     = MAX_ORDER + 1;
   localparam int TREE_NODES = (2 << MAX_ORDER) - 1;
   localparam int ADDR_SPAN  = 1 << MAX_ORDER;
   localparam int AMEM_W     = ORD_W + 1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_OOM     = 2'd1;
   localparam status_type ST_INVALID = 2'd2;

   // heap index of the block of order ord that holds addr
   function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                input logic [ADDR_W-1:0] addr);
      logic [NODE_W-1:0] base;
      base = (NODE_W'(1) << (ORD_W'(MAX_ORDER) - ord)) - NODE_W'(1);
      return base + NODE_W'(addr >> ord);
   endfunction

   // order of the smallest power of two not below req (req nonzero)
   function automatic logic [ORD_W-1:0] round_order(input logic [SIZE_W-1:0] req);
      logic [SIZE_W-1:0] r;
      logic [ORD_W-1:0]  k;
      r = req - SIZE_W'(1);
      k = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (r[i]) k = ORD_W'(i + 1);
      end
      return k;
   endfunction

   function automatic logic [ORD_W-1:0] low_bit(input logic [MASK_W-1:0] m);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) r = ORD_W'(i);
      end
      return r;
   endfunction

   function automatic logic [MASK_W-1:0] low_mask(input logic [ORD_W-1:0] n);
      return (MASK_W'(1) << n) - MASK_W'(1);
   endfunction

endpackage
`default_nettype wire

// ===== sv/bma_if.sv =====
// Request and response channel interfaces of the buddy memory allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bma_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [bma_pkg::SIZE_W-1:0] req_size;
   logic [bma_pkg::ADDR_W-1:0] free_addr;
   modport source (output valid, func, req_size, free_addr, input ready);
   modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

interface bma_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [bma_pkg::ADDR_W-1:0] block_addr;
   logic [bma_pkg::ORD_W-1:0]  block_order;
   modport source (output valid, status, block_addr, block_order, input ready);
   modport sink   (input valid, status, block_addr, block_order, output ready);
endinterface
`default_nettype wire

// ===== sv/buddy_memory_allocator.sv =====
// Binary buddy allocator: top level with sequencer and node-mask tree memory.
// Alloc walks descent, split and climb levels; free walks merge levels, then climb levels;
//   rejected transactions skip the tree walk.
// Throughput: one transaction at a time; the next request is accepted once the response is presented.
// Reset (and any pool_order write) starts a clearing pass of both memories.
`timescale 1ns / 1ps
`default_nettype none
module buddy_memory_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   bma_req_if.sink          req_ch,
   bma_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import bma_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_TOP, S_D_RD, S_D_CHK, S_SPLIT, S_SIB,
      S_CLIMB_RD, S_CLIMB_WR, S_F_CHK, S_M_RD, S_M_CHK, S_M_PAR, S_FINAL, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [ORD_W-1:0]   pool_ff, pool_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [ORD_W-1:0]   ord_ff, ord_in;
   logic [ORD_W-1:0]   k_ff, k_in;
   logic [ORD_W-1:0]   tgt_ff, tgt_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [MASK_W-1:0]  acc_ff, acc_in;
   status_type         res_st_ff, res_st_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [ORD_W-1:0]   res_ord_ff, res_ord_in;
   logic               rv_ff, rv_in;
   status_type         rst_ff, rst_in;
   logic [ADDR_W-1:0]  raddr_ff, raddr_in;
   logic [ORD_W-1:0]   rord_ff, rord_in;

   logic               t_we;
   logic [NODE_W-1:0]  t_wa, t_ra;
   logic [MASK_W-1:0]  t_wd, t_rd;
   logic               a_we;
   logic [ADDR_W-1:0]  a_wa, a_ra;
   logic [AMEM_W-1:0]  a_wd, a_rd;

   logic [ORD_W-1:0]   pe;
   logic               cfg_wr;
   logic [ORD_W-1:0]   kreq;
   logic [MASK_W-1:0]  cand;
   logic [ADDR_W-1:0]  obit;
   logic [ORD_W-1:0]   ford;

   bma_ram #(.WIDTH(MASK_W), .DEPTH(TREE_NODES)) u_tree (
      .clock(clock), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
   );

   bma_ram #(.WIDTH(AMEM_W), .DEPTH(ADDR_SPAN)) u_amem (
      .clock(clock), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd)
   );

   assign pe     = (pool_ff > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : pool_ff;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign pready = 1'b1;
   assign prdata = {28'd0, pool_ff};
   assign kreq   = round_order(req_ch.req_size);
   assign cand   = t_rd & ~low_mask(k_ff);
   assign obit   = ADDR_W'(1) << ord_ff;
   assign ford   = (a_rd[ORD_W-1:0] > pe) ? pe : a_rd[ORD_W-1:0];

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rv_ff;
   assign rsp_ch.status      = rst_ff;
   assign rsp_ch.block_addr  = raddr_ff;
   assign rsp_ch.block_order = rord_ff;

   always_comb begin
      state_in    = state_ff;
      pool_in     = pool_ff;
      clr_in      = clr_ff;
      ord_in      = ord_ff;
      k_in        = k_ff;
      tgt_in      = tgt_ff;
      addr_in     = addr_ff;
      acc_in      = acc_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      res_ord_in  = res_ord_ff;
      rv_in       = rv_ff && !rsp_ch.ready;
      rst_in      = rst_ff;
      raddr_in    = raddr_ff;
      rord_in     = rord_ff;
      t_we        = 1'b0;
      t_wa        = '0;
      t_wd        = '0;
      t_ra        = node_of(pe, '0);
      a_we        = 1'b0;
      a_wa        = addr_ff;
      a_wd        = '0;
      a_ra        = req_ch.free_addr;

      case (state_ff)
         S_CLEAR: begin
            t_we   = 1'b1;
            t_wa   = clr_ff;
            t_wd   = (clr_ff == node_of(pe, '0)) ? (MASK_W'(1) << pe) : '0;
            a_we   = (clr_ff < NODE_W'(ADDR_SPAN));
            a_wa   = clr_ff[ADDR_W-1:0];
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(TREE_NODES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               if (!req_ch.func) begin
                  k_in = kreq;
                  if (req_ch.req_size == '0) begin
                     res_st_in = ST_INVALID; res_addr_in = '0; res_ord_in = '0;
                     state_in  = S_RESP;
                  end else if (kreq > pe) begin
                     res_st_in = ST_OOM; res_addr_in = '0; res_ord_in = kreq;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_A_TOP;
                  end
               end else begin
                  addr_in = req_ch.free_addr;
                  if ((req_ch.free_addr >> pe) != '0) begin
                     res_st_in = ST_INVALID; res_addr_in = req_ch.free_addr;
                     res_ord_in = '0;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_F_CHK;
                  end
               end
            end
         end
         S_A_TOP: begin
            if (cand == '0) begin
               res_st_in = ST_OOM; res_addr_in = '0; res_ord_in = k_ff;
               state_in  = S_RESP;
            end else begin
               tgt_in   = low_bit(cand);
               ord_in   = pe;
               addr_in  = '0;
               state_in = S_D_RD;
            end
         end
         S_D_RD: begin
            t_ra = node_of(ord_ff - ORD_W'(1), addr_ff);
            if (ord_ff == tgt_ff) state_in = S_SPLIT;
            else                  state_in = S_D_CHK;
         end
         S_D_CHK: begin
            if (!t_rd[tgt_ff]) addr_in = addr_ff | (ADDR_W'(1) << (ord_ff - ORD_W'(1)));
            ord_in   = ord_ff - ORD_W'(1);
            state_in = S_D_RD;
         end
         S_SPLIT: begin
            t_we = 1'b1;
            t_wa = node_of(ord_ff, addr_ff);
            t_wd = low_mask(ord_ff) & ~low_mask(k_ff);
            if (ord_ff == k_ff) begin
               a_we        = 1'b1;
               a_wd        = {1'b1, k_ff};
               res_st_in   = ST_OK;
               res_addr_in = addr_ff;
               res_ord_in  = k_ff;
               acc_in      = low_mask(tgt_ff) & ~low_mask(k_ff);
               ord_in      = tgt_ff;
               state_in    = S_CLIMB_RD;
            end else begin
               state_in = S_SIB;
            end
         end
         S_SIB: begin
            t_we     = 1'b1;
            t_wa     = node_of(ord_ff - ORD_W'(1),
                               addr_ff | (ADDR_W'(1) << (ord_ff - ORD_W'(1))));
            t_wd     = MASK_W'(1) << (ord_ff - ORD_W'(1));
            ord_in   = ord_ff - ORD_W'(1);
            state_in = S_SPLIT;
         end
         S_CLIMB_RD: begin
            t_ra = node_of(ord_ff, addr_ff ^ obit);
            if (ord_ff >= pe) state_in = S_RESP;
            else              state_in = S_CLIMB_WR;
         end
         S_CLIMB_WR: begin
            t_we     = 1'b1;
            t_wa     = node_of(ord_ff + ORD_W'(1), addr_ff & ~obit);
            t_wd     = acc_ff | t_rd;
            acc_in   = acc_ff | t_rd;
            addr_in  = addr_ff & ~obit;
            ord_in   = ord_ff + ORD_W'(1);
            state_in = S_CLIMB_RD;
         end
         S_F_CHK: begin
            if (!a_rd[ORD_W]) begin
               res_st_in = ST_INVALID; res_addr_in = addr_ff; res_ord_in = '0;
               state_in  = S_RESP;
            end else begin
               a_we        = 1'b1;
               res_st_in   = ST_OK;
               res_addr_in = addr_ff;
               res_ord_in  = ford;
               ord_in      = ford;
               state_in    = S_M_RD;
            end
         end
         S_M_RD: begin
            t_ra = node_of(ord_ff, addr_ff ^ obit);
            if (ord_ff >= pe) state_in = S_FINAL;
            else              state_in = S_M_CHK;
         end
         S_M_CHK: begin
            if (t_rd[ord_ff]) begin
               t_we     = 1'b1;
               t_wa     = node_of(ord_ff, addr_ff ^ obit);
               addr_in  = addr_ff & ~obit;
               ord_in   = ord_ff + ORD_W'(1);
               state_in = S_M_PAR;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_M_PAR: begin
            t_we     = 1'b1;
            t_wa     = node_of(ord_ff, addr_ff);
            state_in = S_M_RD;
         end
         S_FINAL: begin
            t_we     = 1'b1;
            t_wa     = node_of(ord_ff, addr_ff);
            t_wd     = MASK_W'(1) << ord_ff;
            acc_in   = MASK_W'(1) << ord_ff;
            state_in = S_CLIMB_RD;
         end
         S_RESP: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               rst_in   = res_st_ff;
               raddr_in = res_addr_ff;
               rord_in  = res_ord_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg_wr) begin
         pool_in  = pwdata[ORD_W-1:0];
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pool_ff  <= ORD_W'(MAX_ORDER);
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff  <= pool_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      ord_ff      <= ord_in;
      k_ff        <= k_in;
      tgt_ff      <= tgt_in;
      addr_ff     <= addr_in;
      acc_ff      <= acc_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      res_ord_ff  <= res_ord_in;
      rst_ff      <= rst_in;
      raddr_ff    <= raddr_in;
      rord_ff     <= rord_in;
   end
endmodule
`default_nettype wire

// ===== sv/bma_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
